// ===== design/rsmin_pkg.sv =====
// Package for the rectangle set minimum spacing unit.
// Widths, payload types and the job word passed from front to back.
// No dependencies.
`timescale 1ns / 1ps

package rsmin_pkg;

   localparam int COORD_BITS   = 24;
   localparam int FRAC_BITS    = 8;
   localparam int SPACING_BITS = 33;

   localparam int SUM_BITS   = COORD_BITS + 1;
   localparam int GAP_BITS   = COORD_BITS + 1;
   localparam int SQ_BITS    = 2 * GAP_BITS;
   localparam int SUMSQ_BITS = SQ_BITS + 1;
   localparam int RAD_RAW    = SUMSQ_BITS + 2 * FRAC_BITS;
   localparam int ROOT_BITS  = (RAD_RAW + 1) / 2;
   localparam int RAD_BITS   = 2 * ROOT_BITS;
   localparam int REM_BITS   = ROOT_BITS + 2;
   localparam int STEP_BITS  = $clog2(ROOT_BITS);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   typedef logic [COORD_BITS-1:0]   coord_type;
   typedef logic [SUM_BITS-1:0]     sum_type;
   typedef logic [GAP_BITS-1:0]     gap_type;
   typedef logic [SPACING_BITS-1:0] spacing_type;

   typedef struct packed {
      gap_type gx;
      gap_type gy;
      logic    ovl;
      logic    last;
   } job_type;

   localparam int JOB_BITS = $bits(job_type);

   function automatic coord_type span(input coord_type lo, input coord_type hi);
      span = (hi < lo) ? (lo - hi) : (hi - lo);
   endfunction

endpackage

// ===== design/rsmin_if.sv =====
// Handshake channels of the rectangle set minimum spacing unit.
// Depends on rsmin_pkg.
`timescale 1ns / 1ps

interface rsmin_req_if import rsmin_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type a_left;
   coord_type a_bottom;
   coord_type a_right;
   coord_type a_top;
   coord_type b_left;
   coord_type b_bottom;
   coord_type b_right;
   coord_type b_top;
   logic      last_pair;

   modport source (output valid, a_left, a_bottom, a_right, a_top,
                   b_left, b_bottom, b_right, b_top, last_pair, input ready);
   modport sink   (input valid, a_left, a_bottom, a_right, a_top,
                   b_left, b_bottom, b_right, b_top, last_pair, output ready);
endinterface

interface rsmin_rsp_if import rsmin_pkg::*; ();
   logic        valid;
   logic        ready;
   spacing_type spacing;
   logic        overlap;

   modport source (output valid, spacing, overlap, input ready);
   modport sink   (input valid, spacing, overlap, output ready);
endinterface

// ===== design/rsmin_front.sv =====
// Front end: takes rectangle pairs and reduces each to per-axis gaps.
// Depends on rsmin_pkg and rsmin_req_if.
`timescale 1ns / 1ps

module rsmin_front import rsmin_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rsmin_req_if.sink   req_if,
   output logic        push_valid,
   input  logic        push_ready,
   output job_type     push_data
);

   logic    s1_valid_ff, s1_valid_in;
   sum_type sa_x_ff, sb_x_ff, sz_x_ff;
   sum_type sa_y_ff, sb_y_ff, sz_y_ff;
   logic    last_ff;

   sum_type d_x, d_y;
   logic    in_x, in_y;
   logic    take;

   assign req_if.ready = !s1_valid_ff || push_ready;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (push_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sa_x_ff <= SUM_BITS'(req_if.a_left) + SUM_BITS'(req_if.a_right);
         sb_x_ff <= SUM_BITS'(req_if.b_left) + SUM_BITS'(req_if.b_right);
         sz_x_ff <= SUM_BITS'(span(req_if.a_left, req_if.a_right))
                  + SUM_BITS'(span(req_if.b_left, req_if.b_right));
         sa_y_ff <= SUM_BITS'(req_if.a_bottom) + SUM_BITS'(req_if.a_top);
         sb_y_ff <= SUM_BITS'(req_if.b_bottom) + SUM_BITS'(req_if.b_top);
         sz_y_ff <= SUM_BITS'(span(req_if.a_bottom, req_if.a_top))
                  + SUM_BITS'(span(req_if.b_bottom, req_if.b_top));
         last_ff <= req_if.last_pair;
      end
   end

   always_comb begin
      d_x  = (sa_x_ff > sb_x_ff) ? (sa_x_ff - sb_x_ff) : (sb_x_ff - sa_x_ff);
      d_y  = (sa_y_ff > sb_y_ff) ? (sa_y_ff - sb_y_ff) : (sb_y_ff - sa_y_ff);
      in_x = d_x < sz_x_ff;
      in_y = d_y < sz_y_ff;
      push_data.gx   = in_x ? '0 : GAP_BITS'(d_x - sz_x_ff);
      push_data.gy   = in_y ? '0 : GAP_BITS'(d_y - sz_y_ff);
      push_data.ovl  = in_x && in_y;
      push_data.last = last_ff;
   end

   assign push_valid = s1_valid_ff;

endmodule

// ===== design/rsmin_queue.sv =====
// Short job queue between front and back end.
// Depends on rsmin_pkg.
`timescale 1ns / 1ps

module rsmin_queue import rsmin_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = count_ff != QCNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/rsmin_back.sv =====
// Back end: squares the gaps, takes the square root one bit per cycle,
// keeps the running minimum and emits on the last pair. Depends on rsmin_pkg.
`timescale 1ns / 1ps

module rsmin_back import rsmin_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  job_type     pop_data,
   rsmin_rsp_if.source rsp_if
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_ROOT = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]            state_ff, state_in;
   job_type               job_ff;
   logic [SQ_BITS-1:0]    sq_x_ff, sq_y_ff;
   logic [RAD_BITS-1:0]   rad_ff, rad_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in, rem_t, trial;
   logic [ROOT_BITS-1:0]  root_ff, root_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   spacing_type           min_ff, min_in, cand;
   logic                  seen_ff, seen_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   spacing_type           rsp_spacing_ff;
   logic                  rsp_overlap_ff;
   logic                  emit;
   logic [SUMSQ_BITS-1:0] sumsq;

   assign pop_ready = state_ff == ST_IDLE;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.spacing = rsp_spacing_ff;
   assign rsp_if.overlap = rsp_overlap_ff;

   assign sumsq = SUMSQ_BITS'(sq_x_ff) + SUMSQ_BITS'(sq_y_ff);
   assign rem_t = {rem_ff[REM_BITS-3:0], rad_ff[RAD_BITS-1 -: 2]};
   assign trial = {root_ff, 2'b01};
   assign cand  = spacing_type'(root_ff[ROOT_BITS-1:1]);

   always_comb begin
      state_in     = state_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      min_in       = min_ff;
      seen_in      = seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      emit         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               state_in = pop_data.ovl ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rad_in   = RAD_BITS'(sumsq) << (2 * FRAC_BITS);
            rem_in   = '0;
            root_in  = '0;
            step_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rad_in = rad_ff << 2;
            if (rem_t >= trial) begin
               rem_in  = rem_t - trial;
               root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_in  = rem_t;
               root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(ROOT_BITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (job_ff.ovl) begin
               seen_in = 1'b1;
            end else if (cand < min_ff) begin
               min_in = cand;
            end
            if (!job_ff.last) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_if.ready) begin
               emit         = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               min_in  = min_ff;
               seen_in = seen_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= '1;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (emit) begin
            min_ff  <= '1;
            seen_ff <= 1'b0;
         end else begin
            min_ff  <= min_in;
            seen_ff <= seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
      if (state_ff == ST_IDLE && pop_valid) begin
         job_ff <= pop_data;
      end
      if (state_ff == ST_MUL) begin
         sq_x_ff <= job_ff.gx * job_ff.gx;
         sq_y_ff <= job_ff.gy * job_ff.gy;
      end
      if (emit) begin
         rsp_spacing_ff <= seen_in ? '0 : min_in;
         rsp_overlap_ff <= seen_in;
      end
   end

endmodule

// ===== design/rect_set_min_spacing_unit.sv =====
// Top level of the rectangle set minimum spacing unit.
// Depends on rsmin_pkg, rsmin_if, rsmin_front, rsmin_queue and rsmin_back.
//
//   channel  dir  handshake              word
//   req_if   in   valid/ready            two rectangles and a last-pair mark
//   rsp_if   out  valid/ready            minimum spacing and overlap flag
//
// In the back end a pair passes through pop, square, sum, 34 root
// steps (one root bit per cycle) and a final update; an overlapping pair goes from pop to the update.
// The front end adds one register stage and a four-word queue ahead of it.
// Reset is synchronous and clears the run state to an empty run.
// The result register holds a word while the back end keeps working.
`timescale 1ns / 1ps

module rect_set_min_spacing_unit import rsmin_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rsmin_req_if.sink   req_if,
   rsmin_rsp_if.source rsp_if
);

   logic    push_valid, push_ready;
   job_type push_data;
   logic    pop_valid, pop_ready;
   job_type pop_data;

   rsmin_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   rsmin_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rsmin_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== bench/tb_rect_set_min_spacing_unit.sv =====
// Testbench for rect_set_min_spacing_unit: directed and random rectangle pair runs,
// checked word by word against a spacing predictor kept inside the bench.
// Depends on rsmin_pkg, rsmin_if and the rect_set_min_spacing_unit design files.
`timescale 1ns / 1ps

module tb_rect_set_min_spacing_unit;
   import rsmin_pkg::*;

   localparam int        MAX_SHOWN    = 10;
   localparam int        DRAIN_CYCLES = 250;
   localparam int        RANDOM_PAIRS = 900;
   localparam coord_type COORD_MAX    = '1;

   typedef struct {
      coord_type al;
      coord_type ab;
      coord_type ar;
      coord_type at;
      coord_type bl;
      coord_type bb;
      coord_type br;
      coord_type bt;
      logic      last;
   } rect_pair_type;

   typedef struct {
      spacing_type spacing;
      logic        overlap;
   } spacing_result_type;

   logic clock;
   logic reset;

   rsmin_req_if req_if();
   rsmin_rsp_if rsp_if();

   rect_set_min_spacing_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   spacing_result_type expected_spacing_q[$];
   spacing_result_type got_word;
   spacing_result_type want_word;
   spacing_type        run_min;
   logic               run_overlap;

   int pairs_sent      = 0;
   int results_checked = 0;
   int overlap_runs    = 0;
   int mismatches      = 0;
   int burst_left      = 0;
   int stall_mode      = 0;
   int stall_left      = 0;
   int stall_phase     = 0;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Spacing predictor

   function automatic void axis_extent(input coord_type lo_a, input coord_type hi_a,
                                       input coord_type lo_b, input coord_type hi_b,
                                       output gap_type gap, output logic overlapped);
      coord_type t;
      sum_type   sa;
      sum_type   sb;
      gap_type   d2;
      gap_type   s2;
      if (hi_a < lo_a) begin
         t    = lo_a;
         lo_a = hi_a;
         hi_a = t;
      end
      if (hi_b < lo_b) begin
         t    = lo_b;
         lo_b = hi_b;
         hi_b = t;
      end
      sa         = lo_a + hi_a;
      sb         = lo_b + hi_b;
      d2         = (sa > sb) ? (sa - sb) : (sb - sa);
      s2         = (hi_a - lo_a) + (hi_b - lo_b);
      overlapped = d2 < s2;
      gap        = overlapped ? '0 : (d2 - s2);
   endfunction

   function automatic logic [63:0] floor_root(input logic [127:0] v);
      logic [63:0] root;
      logic [65:0] rem;
      logic [65:0] trial;
      int          i;
      root = '0;
      rem  = '0;
      for (i = 63; i >= 0; i--) begin
         rem   = {rem[63:0], v[2*i+1 -: 2]};
         trial = {root, 2'b01};
         if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[62:0], 1'b1};
         end else begin
            root = {root[62:0], 1'b0};
         end
      end
      return root;
   endfunction

   task automatic predict_pair(input rect_pair_type p);
      gap_type                 gx;
      gap_type                 gy;
      logic                    in_x;
      logic                    in_y;
      logic [SUMSQ_BITS-1:0]   sumsq;
      logic [127:0]            rad;
      logic [63:0]             pair_root;
      spacing_type             pair_gap;
      spacing_result_type      r;
      axis_extent(p.al, p.ar, p.bl, p.br, gx, in_x);
      axis_extent(p.ab, p.at, p.bb, p.bt, gy, in_y);
      if (in_x && in_y) begin
         run_overlap = 1'b1;
      end else begin
         sumsq                 = gx * gx + gy * gy;
         rad                   = '0;
         rad[SUMSQ_BITS-1:0]   = sumsq;
         rad                   = rad << (2 * FRAC_BITS);
         pair_root             = floor_root(rad) >> 1;
         if (pair_root[63:SPACING_BITS] != '0) begin
            pair_gap = '1;
         end else begin
            pair_gap = pair_root[SPACING_BITS-1:0];
         end
         if (pair_gap < run_min) begin
            run_min = pair_gap;
         end
      end
      if (p.last) begin
         r.spacing = run_overlap ? '0 : run_min;
         r.overlap = run_overlap;
         if (run_overlap) begin
            overlap_runs++;
         end
         expected_spacing_q.push_back(r);
         run_min     = '1;
         run_overlap = 1'b0;
      end
   endtask

   // Stimulus helpers

   function automatic rect_pair_type mk_pair(input coord_type al, input coord_type ab,
                                             input coord_type ar, input coord_type at,
                                             input coord_type bl, input coord_type bb,
                                             input coord_type br, input coord_type bt,
                                             input logic last);
      rect_pair_type p;
      p.al   = al;
      p.ab   = ab;
      p.ar   = ar;
      p.at   = at;
      p.bl   = bl;
      p.bb   = bb;
      p.br   = br;
      p.bt   = bt;
      p.last = last;
      return p;
   endfunction

   function automatic void order_edges(inout coord_type lo, inout coord_type hi);
      coord_type t;
      if (hi < lo) begin
         t  = lo;
         lo = hi;
         hi = t;
      end
   endfunction

   function automatic coord_type extreme_coord();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return COORD_MAX;
         2:       return coord_type'(1);
         3:       return COORD_MAX - 1;
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic rect_pair_type random_pair(input logic last);
      rect_pair_type p;
      coord_type     bx;
      coord_type     by;
      int            mode;
      mode = $urandom_range(0, 9);
      p.al = coord_type'($urandom);
      p.ab = coord_type'($urandom);
      p.ar = coord_type'($urandom);
      p.at = coord_type'($urandom);
      p.bl = coord_type'($urandom);
      p.bb = coord_type'($urandom);
      p.br = coord_type'($urandom);
      p.bt = coord_type'($urandom);
      bx   = coord_type'($urandom_range(0, COORD_MAX - 5000));
      by   = coord_type'($urandom_range(0, COORD_MAX - 5000));
      case (mode)
         3, 4, 5: begin
            p.al = bx + coord_type'($urandom_range(0, 255));
            p.ar = p.al + coord_type'($urandom_range(0, 255));
            p.ab = by + coord_type'($urandom_range(0, 255));
            p.at = p.ab + coord_type'($urandom_range(0, 255));
            p.bl = bx + coord_type'($urandom_range(0, 700));
            p.br = p.bl + coord_type'($urandom_range(0, 255));
            p.bb = by + coord_type'($urandom_range(0, 700));
            p.bt = p.bb + coord_type'($urandom_range(0, 255));
         end
         6: begin
            p.al = bx + coord_type'($urandom_range(0, 1000));
            p.ar = p.al + coord_type'($urandom_range(0, 1000));
            p.ab = by + coord_type'($urandom_range(0, 1000));
            p.at = p.ab + coord_type'($urandom_range(0, 1000));
            if ($urandom_range(0, 1) == 0) begin
               p.bl = p.ar;
               p.br = p.bl + coord_type'($urandom_range(0, 1000));
               p.bb = by + coord_type'($urandom_range(0, 2500));
               p.bt = p.bb + coord_type'($urandom_range(0, 1000));
            end else begin
               p.bb = p.at;
               p.bt = p.bb + coord_type'($urandom_range(0, 1000));
               p.bl = bx + coord_type'($urandom_range(0, 2500));
               p.br = p.bl + coord_type'($urandom_range(0, 1000));
            end
         end
         7: begin
            p.al = extreme_coord();
            p.ab = extreme_coord();
            p.ar = extreme_coord();
            p.at = extreme_coord();
            p.bl = extreme_coord();
            p.bb = extreme_coord();
            p.br = extreme_coord();
            p.bt = extreme_coord();
         end
         9: begin
            p.ar = p.al;
            p.at = p.ab;
            p.br = p.bl;
            p.bt = p.bb;
         end
         default: ;
      endcase
      // keep reversed edges in mode 8 only
      if (mode != 8) begin
         order_edges(p.al, p.ar);
         order_edges(p.ab, p.at);
         order_edges(p.bl, p.br);
         order_edges(p.bb, p.bt);
      end
      p.last = last;
      return p;
   endfunction

   task automatic send_pair(input rect_pair_type p);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
      req_if.valid     <= 1'b1;
      req_if.a_left    <= p.al;
      req_if.a_bottom  <= p.ab;
      req_if.a_right   <= p.ar;
      req_if.a_top     <= p.at;
      req_if.b_left    <= p.bl;
      req_if.b_bottom  <= p.bb;
      req_if.b_right   <= p.br;
      req_if.b_top     <= p.bt;
      req_if.last_pair <= p.last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      burst_left--;
      pairs_sent++;
      predict_pair(p);
   endtask

   task automatic wait_results_drained();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (expected_spacing_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Test tasks

   task automatic test_axis_gaps();
      send_pair(mk_pair(0, 0, 10, 10, 20, 0, 30, 10, 1'b1));
      send_pair(mk_pair(0, 0, 10, 10, 0, 25, 10, 40, 1'b1));
      send_pair(mk_pair(0, 0, 0, 0, 3, 4, 3, 4, 1'b1));
      send_pair(mk_pair(0, 0, 0, 0, 1, 1, 1, 1, 1'b1));
   endtask

   task automatic test_special_cases();
      send_pair(mk_pair(0, 0, 10, 10, 10, 0, 20, 10, 1'b1));
      send_pair(mk_pair(0, 0, 10, 10, 10, 10, 20, 20, 1'b1));
      send_pair(mk_pair(0, 0, 10, 10, 5, 5, 15, 15, 1'b1));
      send_pair(mk_pair(10, 10, 0, 0, 30, 0, 20, 10, 1'b1));
      send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
      send_pair(mk_pair(0, 0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
      send_pair(mk_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
      send_pair(mk_pair(0, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 1'b1));
   endtask

   task automatic test_run_merging();
      send_pair(mk_pair(0, 0, 10, 10, 100, 0, 110, 10, 1'b0));
      send_pair(mk_pair(0, 0, 10, 10, 30, 0, 40, 10, 1'b0));
      send_pair(mk_pair(0, 0, 10, 10, 60, 0, 70, 10, 1'b1));
      send_pair(mk_pair(0, 0, 10, 10, 2, 2, 4, 4, 1'b0));
      send_pair(mk_pair(0, 0, 10, 10, 5000, 9000, 6000, 9500, 1'b1));
      send_pair(mk_pair(0, 0, 10, 10, 5000, 9000, 6000, 9500, 1'b1));
      send_pair(mk_pair(0, 0, 1, 1, 2, 2, 3, 3, 1'b0));
      send_pair(mk_pair(0, 0, 1, 1, COORD_MAX, 0, COORD_MAX, 1, 1'b1));
   endtask

   task automatic test_random_runs();
      int len;
      int k;
      int sent;
      bit paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < RANDOM_PAIRS) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
         for (k = 0; k < len; k++) begin
            send_pair(random_pair(k == len - 1));
         end
         sent += len;
         // hold the sender once until the result side is empty
         if (!paused && sent >= RANDOM_PAIRS / 2) begin
            wait_results_drained();
            paused = 1'b1;
         end
      end
   endtask

   // Result side

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(50, 300);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
         0:       rsp_if.ready <= 1'b1;
         1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
         2:       rsp_if.ready <= ((stall_phase % 7) < 3);
         default: rsp_if.ready <= ((stall_phase % 32) >= 20);
      endcase
   end

   task automatic note_mismatch(input string what, input spacing_result_type want,
                                input spacing_result_type got);
      mismatches++;
      if (mismatches <= MAX_SHOWN) begin
         $display("%t: %s: expected spacing %0d overlap %0b, got spacing %0d overlap %0b",
                  $realtime, what, want.spacing, want.overlap, got.spacing, got.overlap);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got_word.spacing = rsp_if.spacing;
         got_word.overlap = rsp_if.overlap;
         if (expected_spacing_q.size() == 0) begin
            want_word.spacing = '0;
            want_word.overlap = 1'b0;
            note_mismatch("unexpected word", want_word, got_word);
         end else begin
            want_word = expected_spacing_q.pop_front();
            results_checked++;
            if (got_word.spacing !== want_word.spacing ||
                got_word.overlap !== want_word.overlap) begin
               note_mismatch("wrong word", want_word, got_word);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d words still expected", expected_spacing_q.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.a_left    = '0;
      req_if.a_bottom  = '0;
      req_if.a_right   = '0;
      req_if.a_top     = '0;
      req_if.b_left    = '0;
      req_if.b_bottom  = '0;
      req_if.b_right   = '0;
      req_if.b_top     = '0;
      req_if.last_pair = 1'b0;
      rsp_if.ready     = 1'b0;
      run_min          = '1;
      run_overlap      = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_axis_gaps();
      test_special_cases();
      test_run_merging();
      wait_results_drained();
      test_random_runs();
      wait_results_drained();
      $display("Sent %0d rectangle pairs, checked %0d spacing words, %0d runs overlapped.",
               pairs_sent, results_checked, overlap_runs);
      $display("Mismatches: %0d, words left waiting: %0d",
               mismatches, expected_spacing_q.size());
      if (mismatches == 0 && expected_spacing_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
